[design/dgrad_pkg.sv]
// Shared types, constants and arithmetic helpers for the 2x2 difference gradient.
// Used by every module of the block but dgrad_ram; depends on nothing else.
`default_nettype none

package dgrad_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int DIM_W       = 12;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int PIX_W       = 8;
    localparam int OUT_POS_W   = 11;
    localparam int MAG_W       = 8;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 32;
    localparam int PAD_W       = OUT_DATA_W - 2 * OUT_POS_W - MAG_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W   = 2;

    // Result slots of one pixel, in raster order of the pixels they tag.
    localparam int RES_UPPER_LEFT  = 0;
    localparam int RES_UPPER       = 1;
    localparam int RES_LEFT        = 2;
    localparam int RES_CURRENT     = 3;
    localparam int RES_N           = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_GRADIENT_MODE = 2'd2
    } cfg_index_t;

    typedef enum logic {
        MODE_HV      = 1'b0,
        MODE_ROBERTS = 1'b1
    } gradient_mode_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] ul;
        logic [PIX_W-1:0] lf;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [RES_N-1:0] mask;
    } dgrad_task_t;

    function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [MAG_W-1:0] grad(input gradient_mode_t mode,
                                              input logic [PIX_W-1:0] centre,
                                              input logic [PIX_W-1:0] right,
                                              input logic [PIX_W-1:0] below,
                                              input logic [PIX_W-1:0] br);
        logic [PIX_W:0] sum;
        if (mode == MODE_ROBERTS)
            sum = {1'b0, absdiff(br, centre)} + {1'b0, absdiff(right, below)};
        else
            sum = {1'b0, absdiff(below, centre)} + {1'b0, absdiff(right, centre)};
        return sum[PIX_W] ? {MAG_W{1'b1}} : sum[MAG_W-1:0];
    endfunction

    // Index of the last column or row for a register value clamped to 1..max.
    function automatic logic [DIM_W-1:0] last_index(input logic [DIM_W-1:0] v,
                                                    input int max);
        if (v == '0)
            return '0;
        else if (int'(v) > max)
            return DIM_W'(max - 1);
        else
            return v - 1'b1;
    endfunction

endpackage

`default_nettype wire

[design/dgrad_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; a read and a write at the same address return the old data.
`default_nettype none

module dgrad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/dgrad_front.sv]
// Front end: accepts pixels, tracks row and column, reads and updates the line store
// and builds one task per pixel for the queue. Uses dgrad_pkg and dgrad_ram.
`default_nettype none

module dgrad_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [dgrad_pkg::DIM_W-1:0]   image_width,
    input  wire logic [dgrad_pkg::DIM_W-1:0]   image_height,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [dgrad_pkg::PIX_W-1:0]   pixel,
    output logic                               task_valid,
    input  wire logic                          task_ready,
    output dgrad_pkg::dgrad_task_t             task_data
);

    logic                          accept;
    logic                          push;
    logic [dgrad_pkg::DIM_W-1:0]   w_last;
    logic [dgrad_pkg::DIM_W-1:0]   h_last;
    logic                          last_col;
    logic                          last_row;
    logic [dgrad_pkg::PIX_W-1:0]   up_pix;

    logic [dgrad_pkg::COL_W-1:0]   col_reg;
    logic [dgrad_pkg::ROW_W-1:0]   row_reg;
    logic [dgrad_pkg::PIX_W-1:0]   ul_reg;
    logic [dgrad_pkg::PIX_W-1:0]   lf_reg;
    logic                          s1_valid_reg;
    logic [dgrad_pkg::PIX_W-1:0]   s1_pix_reg;
    logic [dgrad_pkg::COL_W-1:0]   s1_col_reg;
    logic [dgrad_pkg::ROW_W-1:0]   s1_row_reg;
    logic                          s1_last_col_reg;
    logic                          s1_last_row_reg;

    assign w_last   = dgrad_pkg::last_index(image_width, dgrad_pkg::MAX_WIDTH);
    assign h_last   = dgrad_pkg::last_index(image_height, dgrad_pkg::MAX_HEIGHT);
    // Compared with >= so that a shrunk geometry ends the row or frame at once.
    assign last_col = int'(col_reg) >= int'(w_last);
    assign last_row = int'(row_reg) >= int'(h_last);

    assign push     = s1_valid_reg && task_ready;
    assign s_tready = !s1_valid_reg || push;
    assign accept   = s_tvalid && s_tready;

    // The line store is read and overwritten at the same column on acceptance;
    // the read port returns the previous row's pixel in the next cycle and holds it.
    dgrad_ram #(
        .WIDTH (dgrad_pkg::PIX_W),
        .DEPTH (dgrad_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (pixel),
        .re    (accept),
        .raddr (col_reg),
        .rdata (up_pix)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            ul_reg       <= '0;
            lf_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            else if (push)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (push)
            begin
                ul_reg <= up_pix;
                lf_reg <= s1_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg      <= pixel;
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
        end
    end

    always_comb
    begin
        task_data.pix  = s1_pix_reg;
        task_data.up   = up_pix;
        task_data.ul   = ul_reg;
        task_data.lf   = lf_reg;
        task_data.col  = s1_col_reg;
        task_data.row  = s1_row_reg;
        task_data.mask[dgrad_pkg::RES_UPPER_LEFT] = (s1_row_reg != '0) && (s1_col_reg != '0);
        task_data.mask[dgrad_pkg::RES_UPPER]      = (s1_row_reg != '0) && s1_last_col_reg;
        task_data.mask[dgrad_pkg::RES_LEFT]       = s1_last_row_reg && (s1_col_reg != '0);
        task_data.mask[dgrad_pkg::RES_CURRENT]    = s1_last_row_reg && s1_last_col_reg;
    end

    assign task_valid = s1_valid_reg;

`ifndef SYNTHESIS
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel did not reach the front stage");

    a_stalled_task_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (task_valid && !task_ready) |=> (task_valid && $stable(task_data)))
        else $error("stalled task changed before the queue took it");
`endif

endmodule

`default_nettype wire

[design/dgrad_queue.sv]
// Short task queue between the front end and the result generator.
// Uses dgrad_pkg for the task type and depth.
`default_nettype none

module dgrad_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire dgrad_pkg::dgrad_task_t in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output dgrad_pkg::dgrad_task_t     out_data
);

    dgrad_pkg::dgrad_task_t            slots [dgrad_pkg::QUEUE_DEPTH];
    logic [dgrad_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [dgrad_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [dgrad_pkg::QPTR_W:0]        count_reg;
    logic                              push;
    logic                              pop;

    assign in_ready  = count_reg != (dgrad_pkg::QPTR_W + 1)'(dgrad_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slots[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == dgrad_pkg::QPTR_W'(dgrad_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == dgrad_pkg::QPTR_W'(dgrad_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

[design/dgrad_back.sv]
// Back end: takes tasks from the queue and, while m_tready allows, issues results one per cycle
// through an output register. Uses dgrad_pkg for the task type and gradient function.
`default_nettype none

module dgrad_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire dgrad_pkg::gradient_mode_t        gradient_mode,
    input  wire logic                             task_valid,
    output logic                                  task_ready,
    input  wire dgrad_pkg::dgrad_task_t           task_data,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [dgrad_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                  m_tlast
);

    dgrad_pkg::dgrad_task_t                rec_reg;
    logic [dgrad_pkg::RES_N-1:0]           mask_reg;
    logic                                  out_valid_reg;
    logic [dgrad_pkg::OUT_POS_W-1:0]       out_row_reg;
    logic [dgrad_pkg::OUT_POS_W-1:0]       out_col_reg;
    logic [dgrad_pkg::MAG_W-1:0]           out_mag_reg;
    logic                                  out_last_reg;

    logic                                  can_emit;
    logic                                  fire;
    logic [dgrad_pkg::RES_N-1:0]           mask_after;
    logic                                  load;
    logic [1:0]                            sel;
    logic [dgrad_pkg::ROW_W-1:0]           res_row;
    logic [dgrad_pkg::COL_W-1:0]           res_col;
    logic [dgrad_pkg::MAG_W-1:0]           res_mag;
    logic                                  res_last;

    assign can_emit   = !out_valid_reg || m_tready;
    assign fire       = can_emit && (mask_reg != '0);
    assign mask_after = fire ? (mask_reg & (mask_reg - 1'b1)) : mask_reg;
    // A new task is taken in the same cycle as the last result of the current one.
    assign load       = mask_after == '0;
    assign task_ready = load;

    always_comb
    begin
        if (mask_reg[dgrad_pkg::RES_UPPER_LEFT])
            sel = 2'(dgrad_pkg::RES_UPPER_LEFT);
        else if (mask_reg[dgrad_pkg::RES_UPPER])
            sel = 2'(dgrad_pkg::RES_UPPER);
        else if (mask_reg[dgrad_pkg::RES_LEFT])
            sel = 2'(dgrad_pkg::RES_LEFT);
        else
            sel = 2'(dgrad_pkg::RES_CURRENT);
    end

    always_comb
    begin
        unique case (sel)
            2'(dgrad_pkg::RES_UPPER_LEFT):
            begin
                res_row  = rec_reg.row - 1'b1;
                res_col  = rec_reg.col - 1'b1;
                res_mag  = dgrad_pkg::grad(gradient_mode, rec_reg.ul, rec_reg.up,
                                           rec_reg.lf, rec_reg.pix);
                res_last = 1'b0;
            end
            2'(dgrad_pkg::RES_UPPER):
            begin
                res_row  = rec_reg.row - 1'b1;
                res_col  = rec_reg.col;
                res_mag  = dgrad_pkg::grad(gradient_mode, rec_reg.up, rec_reg.up,
                                           rec_reg.pix, rec_reg.pix);
                res_last = 1'b0;
            end
            2'(dgrad_pkg::RES_LEFT):
            begin
                res_row  = rec_reg.row;
                res_col  = rec_reg.col - 1'b1;
                res_mag  = dgrad_pkg::grad(gradient_mode, rec_reg.lf, rec_reg.pix,
                                           rec_reg.lf, rec_reg.pix);
                res_last = 1'b0;
            end
            default:
            begin
                res_row  = rec_reg.row;
                res_col  = rec_reg.col;
                res_mag  = dgrad_pkg::grad(gradient_mode, rec_reg.pix, rec_reg.pix,
                                           rec_reg.pix, rec_reg.pix);
                res_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load)
            begin
                mask_reg <= task_valid ? task_data.mask : '0;
            end
            else
            begin
                mask_reg <= mask_after;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && task_valid)
        begin
            rec_reg <= task_data;
        end
        if (fire)
        begin
            out_row_reg  <= dgrad_pkg::OUT_POS_W'(res_row);
            out_col_reg  <= dgrad_pkg::OUT_POS_W'(res_col);
            out_mag_reg  <= res_mag;
            out_last_reg <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{dgrad_pkg::PAD_W{1'b0}}, out_mag_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_fire_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("issued result did not appear on the output");
`endif

endmodule

`default_nettype wire

[design/difference_gradient_2x2_top.sv]
// Top level of the 2x2 difference gradient: configuration registers and the
// front end, task queue and back end. Uses dgrad_pkg and all dgrad_* modules.
//
// Gray pixels enter in raster order, one per clock, and each gives a gradient
// magnitude tagged with its row and column, one row and one column late; the
// bottom row's results come with that row's pixels and the frame's last pixel
// carries tlast. A pixel leaves zero to four results, and the output issues one
// result per clock while m_tready is high, so inside a frame the block sustains
// one pixel per cycle; at row ends and along the bottom row the extra results
// take output slots, and the input stalls once the four-entry queue is full.
// The line store is a single 2048 x 8 RAM read and written at the same column
// per pixel; it is not cleared after reset, which needs no clearing pass as no
// first-row result uses what it reads. The user must write registers only while
// the block is idle; the block itself does not enforce it.
`default_nettype none

module difference_gradient_2x2_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [dgrad_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dgrad_pkg::DIM_W-1:0]         cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata: [7:0] pixel
    input  wire logic [dgrad_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // m_tdata: [10:0] out_row, [21:11] out_col, [29:22] magnitude, rest zero
    output logic [dgrad_pkg::OUT_DATA_W-1:0]         m_tdata,
    // m_tlast: frame_end
    output logic                                     m_tlast
);

    logic [dgrad_pkg::DIM_W-1:0]   image_width_reg;
    logic [dgrad_pkg::DIM_W-1:0]   image_height_reg;
    dgrad_pkg::gradient_mode_t     gradient_mode_reg;

    logic                          q_in_valid;
    logic                          q_in_ready;
    dgrad_pkg::dgrad_task_t        q_in_data;
    logic                          q_out_valid;
    logic                          q_out_ready;
    dgrad_pkg::dgrad_task_t        q_out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= dgrad_pkg::DIM_W'(640);
            image_height_reg  <= dgrad_pkg::DIM_W'(480);
            gradient_mode_reg <= dgrad_pkg::MODE_HV;
        end
        else if (cfg_we)
        begin
            unique case (dgrad_pkg::cfg_index_t'(cfg_index))
                dgrad_pkg::CFG_IMAGE_WIDTH:   image_width_reg  <= cfg_wdata;
                dgrad_pkg::CFG_IMAGE_HEIGHT:  image_height_reg <= cfg_wdata;
                dgrad_pkg::CFG_GRADIENT_MODE:
                    gradient_mode_reg <= dgrad_pkg::gradient_mode_t'(cfg_wdata[0]);
                default:
                begin
                end
            endcase
        end
    end

    dgrad_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .pixel        (s_tdata[dgrad_pkg::PIX_W-1:0]),
        .task_valid   (q_in_valid),
        .task_ready   (q_in_ready),
        .task_data    (q_in_data)
    );

    dgrad_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    dgrad_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .gradient_mode (gradient_mode_reg),
        .task_valid    (q_out_valid),
        .task_ready    (q_out_ready),
        .task_data     (q_out_data),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule

`default_nettype wire
